// ===== design/ctbe_pkg.sv =====
// ctbe_pkg: shared constants, types and codes for the cursor tracker.
// No dependencies; imported by every module of the block.
package ctbe_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int COORD_BITS   = 12;
    localparam int LIMIT_BITS   = 12;
    localparam int MOTION_BITS  = 16;
    localparam int COUNT_BITS   = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam int SUM_BITS     = MOTION_BITS + 2;

    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    typedef logic [1:0] phase_t;

    localparam phase_t PH_UP       = 2'd0;
    localparam phase_t PH_PRESSED  = 2'd1;
    localparam phase_t PH_DOWN     = 2'd2;
    localparam phase_t PH_RELEASED = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BUTTON_COUNT  = 2'd2;

    localparam logic [LIMIT_BITS-1:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [LIMIT_BITS-1:0] RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [COUNT_BITS-1:0] RST_BUTTON_COUNT  = 4'd8;

    typedef struct packed {
        logic load;
        logic track;
    } lane_ctrl_t;

endpackage

// ===== design/ctbe_axis.sv =====
// ctbe_axis: one axis lane; keeps the cursor coordinate, adds motion, clamps.
// Depends on ctbe_pkg.
module ctbe_axis import ctbe_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [MOTION_BITS-1:0] motion,
    input  logic [LIMIT_BITS-1:0]         limit,
    output logic [COORD_BITS-1:0]         pos_next
);

    logic [COORD_BITS-1:0]      pos_reg;
    logic [COORD_BITS-1:0]      lim;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] lim_ext;

    always_comb begin
        if (SUM_BITS'(limit) > SUM_BITS'(COORD_MAX)) begin
            lim = COORD_MAX;
        end else begin
            lim = COORD_BITS'(limit);
        end
        lim_ext = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, lim});
        sum = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, pos_reg}) + SUM_BITS'(motion);
        if (sum < 0) begin
            pos_next = '0;
        end else if (sum > lim_ext) begin
            pos_next = lim;
        end else begin
            pos_next = sum[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (load) begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== design/ctbe_button.sv =====
// ctbe_button: one button lane; four-phase edge tracker (up/pressed/down/released).
// Depends on ctbe_pkg.
module ctbe_button import ctbe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    input  logic       held,
    output phase_t     phase_next
);

    phase_t phase_reg;

    always_comb begin
        if (!ctrl.track) begin
            phase_next = PH_UP;
        end else if (held) begin
            phase_next = (phase_reg == PH_UP) ? PH_PRESSED : PH_DOWN;
        end else begin
            phase_next = (phase_reg == PH_DOWN) ? PH_RELEASED : PH_UP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_UP;
        end else if (ctrl.load) begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== design/cursor_tracker_button_edges.sv =====
// cursor_tracker_button_edges: top level; config regs, axis and button lanes, merge.
// Latency: result beat appears the cycle after the input beat is accepted.
// Throughput: one report per cycle unless m_ready stalls; the lanes and the output register overlap.
// The output register frees s_ready whenever it is empty or being drained.
// Reset (aresetn low, synchronous): cursor at 0,0, all buttons up, regs to defaults.
// Depends on ctbe_pkg, ctbe_axis, ctbe_button.
module cursor_tracker_button_edges import ctbe_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [MOTION_BITS-1:0] s_motion_x,
    input  logic signed [MOTION_BITS-1:0] s_motion_y,
    input  logic [NUM_BUTTONS-1:0]        s_button_bits,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_BITS-1:0]         m_cursor_x,
    output logic [COORD_BITS-1:0]         m_cursor_y,
    output logic [2*NUM_BUTTONS-1:0]      m_button_phases
);

    logic [LIMIT_BITS-1:0] width_reg;
    logic [LIMIT_BITS-1:0] height_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_eff;

    logic accept;
    logic m_valid_reg;
    logic [COORD_BITS-1:0]    x_next, y_next;
    logic [COORD_BITS-1:0]    cursor_x_reg, cursor_y_reg;
    logic [2*NUM_BUTTONS-1:0] phases_reg;
    logic [2*NUM_BUTTONS-1:0] phases_next;
    phase_t                   lane_phase [NUM_BUTTONS];
    lane_ctrl_t               lane_ctrl  [NUM_BUTTONS];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_SCREEN_WIDTH;
            height_reg <= RST_SCREEN_HEIGHT;
            count_reg  <= RST_BUTTON_COUNT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= LIMIT_BITS'(cfg_wdata);
                REG_SCREEN_HEIGHT: height_reg <= LIMIT_BITS'(cfg_wdata);
                REG_BUTTON_COUNT:  count_reg  <= cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign count_eff = (count_reg > COUNT_BITS'(NUM_BUTTONS)) ?
                       COUNT_BITS'(NUM_BUTTONS) : count_reg;

    ctbe_axis u_axis_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .motion   (s_motion_x),
        .limit    (width_reg),
        .pos_next (x_next)
    );

    ctbe_axis u_axis_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .motion   (s_motion_y),
        .limit    (height_reg),
        .pos_next (y_next)
    );

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        assign lane_ctrl[i] = {accept, (COUNT_BITS'(i) < count_eff)};

        ctbe_button u_btn (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (lane_ctrl[i]),
            .held       (s_button_bits[i]),
            .phase_next (lane_phase[i])
        );

        assign phases_next[2*i +: 2] = lane_phase[i];
    end

    // merge stage: output register holds one finished beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cursor_x_reg <= x_next;
            cursor_y_reg <= y_next;
            phases_reg   <= phases_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_x      = cursor_x_reg;
    assign m_cursor_y      = cursor_y_reg;
    assign m_button_phases = phases_reg;

endmodule

// ===== design/ctbe_checker.sv =====
// ctbe_checker: port-level assertions for cursor_tracker_button_edges, bound to the top.
// Depends on ctbe_pkg.
module ctbe_checker import ctbe_pkg::*; (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [COORD_BITS-1:0]         m_cursor_x,
    input logic [COORD_BITS-1:0]         m_cursor_y,
    input logic [2*NUM_BUTTONS-1:0]      m_button_phases
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    a_accept_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat produced no result");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_x) && $stable(m_cursor_y)
            && $stable(m_button_phases))
        else $error("stalled result beat changed");

endmodule

bind cursor_tracker_button_edges ctbe_checker u_ctbe_checker (.*);
